/* design/kres_pkg.sv */
// Package for the keyed record exchange sort unit.
// Holds record and queue types, field widths and the sequencer state type.
// No dependencies.
package kres_pkg;

   // field widths and defaults
   localparam int KEY_W        = 16;
   localparam int PAY_W        = 8;
   localparam int CAPACITY_DEF = 32;
   localparam int QUEUE_DEPTH  = 2;

   // one stored record: key plus its two payload values
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] first;
      logic [PAY_W-1:0] second;
   } record_type;

   // one request as it sits in the queue
   typedef struct packed {
      record_type rec;
      logic       last;
   } item_type;

   // queue head as seen by the sort engine
   typedef struct packed {
      logic     avail;
      item_type item;
   } q_link_type;

   // sort engine sequencer
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_LD_I,
      ST_SCAN,
      ST_PUT_I,
      ST_EMIT
   } state_type;

endpackage

/* design/kres_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kres_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/kres_front.sv */
// Front end: accepts requests and holds them in a short queue for the sort engine.
// Depends on kres_pkg.
module kres_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kres_pkg::item_type    push_item,
   output logic                  full,
   input  logic                  pop,
   output kres_pkg::q_link_type  q_link
);
   import kres_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full    = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (fill_ff != '0);

   // pointer and fill count update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= push_item;
      end
   end

   assign q_link.avail = (fill_ff != '0);
   assign q_link.item  = slot_ff[head_ff];

endmodule

/* design/kres_back.sv */
// Back end: stores records, runs the exchange sort over the record RAM and emits the set.
// Depends on kres_pkg and kres_ram.
module kres_back #(
   parameter int CAPACITY = kres_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sort_ascending,
   input  kres_pkg::q_link_type  q_link,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic                  rsp_last,
   output kres_pkg::record_type  rsp_rec
);
   import kres_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int REC_W = $bits(record_type);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   record_type        cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              we;
   logic [IDX_W-1:0]  waddr, raddr;
   record_type        wdata;
   logic [REC_W-1:0]  rd_data;
   record_type        rd_rec;

   logic              cnt_full;
   logic [CNT_W-1:0]  n_next;
   logic [CNT_W-1:0]  j_plus;
   logic [CNT_W-1:0]  i_plus1;
   logic [CNT_W-1:0]  i_plus2;
   logic              swap;

   assign rd_rec   = record_type'(rd_data);
   assign cnt_full = (cnt_ff == CNT_W'(CAPACITY));
   assign n_next   = cnt_full ? cnt_ff : cnt_ff + CNT_W'(1);
   assign j_plus   = CNT_W'(j_ff) + CNT_W'(1);
   assign i_plus1  = CNT_W'(i_ff) + CNT_W'(1);
   assign i_plus2  = CNT_W'(i_ff) + CNT_W'(2);

   // strict out-of-order test between held record i and record j
   assign swap = sort_ascending ? (cur_ff.key > rd_rec.key) : (cur_ff.key < rd_rec.key);

   // record store
   kres_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (q_link.avail && q_link.item.last) begin
               state_in = (n_next >= CNT_W'(2)) ? ST_LD_I : ST_EMIT;
            end
         end
         ST_LD_I: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (j_plus >= n_ff) begin
               state_in = ST_PUT_I;
            end
         end
         ST_PUT_I: begin
            state_in = (i_plus2 < n_ff) ? ST_LD_I : ST_EMIT;
         end
         ST_EMIT: begin
            if (j_plus == n_ff) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop          = 1'b0;
      we           = 1'b0;
      waddr        = j_ff;
      wdata        = cur_ff;
      raddr        = j_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            pop = q_link.avail;
            if (q_link.avail) begin
               // store unless the set is full
               if (!cnt_full) begin
                  we     = 1'b1;
                  waddr  = cnt_ff[IDX_W-1:0];
                  wdata  = q_link.item.rec;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               // closing record: fetch record 0 and start the passes
               if (q_link.item.last) begin
                  n_in   = n_next;
                  cnt_in = '0;
                  i_in   = '0;
                  raddr  = '0;
                  j_in   = (n_next >= CNT_W'(2)) ? IDX_W'(1) : '0;
               end
            end
         end
         ST_LD_I: begin
            // hold record i, fetch the first later record
            cur_in = rd_rec;
            raddr  = j_ff;
         end
         ST_SCAN: begin
            // exchange held record with record j when out of order
            if (swap) begin
               we     = 1'b1;
               waddr  = j_ff;
               wdata  = cur_ff;
               cur_in = rd_rec;
            end
            if (j_plus < n_ff) begin
               raddr = j_plus[IDX_W-1:0];
               j_in  = j_plus[IDX_W-1:0];
            end
         end
         ST_PUT_I: begin
            // settle position i, fetch the next one
            we    = 1'b1;
            waddr = i_ff;
            wdata = cur_ff;
            if (i_plus2 < n_ff) begin
               i_in  = i_plus1[IDX_W-1:0];
               raddr = i_plus1[IDX_W-1:0];
               j_in  = i_plus2[IDX_W-1:0];
            end else begin
               j_in = '0;
            end
         end
         ST_EMIT: begin
            // read out in order, data shows up in the next cycle
            raddr        = j_ff;
            rsp_valid_in = 1'b1;
            rsp_last_in  = (j_plus == n_ff);
            j_in         = j_plus[IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      cur_ff <= cur_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_rec   = rd_rec;

endmodule

/* design/keyed_record_exchange_sort_unit.sv */
// Keyed record exchange sort unit: loads a set of records, sorts it in place, emits it.
// Flow: each request passes through the front queue into the record store; the n records
// of a set are then sorted by compare-and-swap passes on the one-read, one-write record
// RAM, and n results follow one per cycle once sorting ends. Requests of a following
// set wait in the front queue until the current set has been emitted.
// Results cannot be stalled. Synchronous reset empties the queue and the set and
// clears the order bit to descending. Depends on kres_pkg, kres_front, kres_back.
module keyed_record_exchange_sort_unit #(
   parameter int CAPACITY = kres_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // requests
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_sort_key,
   input  logic [7:0]  req_payload_first,
   input  logic [7:0]  req_payload_second,
   input  logic        req_is_last,
   // results
   output logic        rsp_valid,
   output logic [15:0] rsp_out_key,
   output logic [7:0]  rsp_out_first,
   output logic [7:0]  rsp_out_second,
   output logic        rsp_out_last,
   // order register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);
   import kres_pkg::*;

   logic        sort_ascending_ff, sort_ascending_in;
   item_type    push_item;
   q_link_type  q_link;
   logic        q_full;
   logic        q_pop;
   logic        rsp_last;
   record_type  rsp_rec;

   // order register
   assign csr_ready = 1'b1;
   assign sort_ascending_in = (csr_valid && csr_ready) ? csr_data : sort_ascending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_ascending_ff <= 1'b0;
      end else begin
         sort_ascending_ff <= sort_ascending_in;
      end
   end

   // request packing
   assign push_item.rec.key    = req_sort_key;
   assign push_item.rec.first  = req_payload_first;
   assign push_item.rec.second = req_payload_second;
   assign push_item.last       = req_is_last;
   assign busy                 = q_full;

   kres_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (start),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .q_link    (q_link)
   );

   kres_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .sort_ascending (sort_ascending_ff),
      .q_link         (q_link),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_last       (rsp_last),
      .rsp_rec        (rsp_rec)
   );

   assign rsp_out_key    = rsp_rec.key;
   assign rsp_out_first  = rsp_rec.first;
   assign rsp_out_second = rsp_rec.second;
   assign rsp_out_last   = rsp_last;

   // results of one set come out on consecutive cycles
   a_emit_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |=> rsp_valid)
      else $error("result burst broken before last result");

   // a set's last result is followed by a gap
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |=> !rsp_valid)
      else $error("result right after last result of a set");

   // reset leaves no result on the port
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule
